// File: design/utf8_sequence_filter_macros.svh
// assertion macros shared by the utf-8 sequence filter
`ifndef UTF8_SEQUENCE_FILTER_MACROS_SVH
`define UTF8_SEQUENCE_FILTER_MACROS_SVH

// condition and consequence in the same cycle
`define USF_ASSERT_NOW(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define USF_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: design/usf_pkg.sv
// types, constants and helpers of the utf-8 sequence filter
`timescale 1ns / 1ps

package usf_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    // bytes released by one input transaction, bytes[0] goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } t_burst;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = SEQ_NONE;
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            len = SEQ_TWO;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            len = SEQ_THREE;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            len = SEQ_FOUR;
        end
        return len;
    endfunction

endpackage

// File: design/usf_front.sv
// front end: accepts text bytes, tracks open sequences and builds release bursts
`timescale 1ns / 1ps

module usf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [7:0]      i_s_tdata,   // [7:0] text_byte
    input  logic            i_s_tlast,   // string_end
    input  logic            i_q_ready,
    output logic            o_q_push,
    output usf_pkg::t_burst o_q_burst
);
    import usf_pkg::*;

    logic [7:0] r_held [3];
    logic [1:0] r_held_count;
    logic [2:0] r_seq_len;

    logic [1:0] n_held_count;
    logic [2:0] n_seq_len;
    logic       w_accept;
    logic       w_cont;
    logic       w_taken;
    logic       w_emit;
    logic [1:0] w_emit_held;
    logic       w_wr_en;
    logic [1:0] w_wr_idx;
    logic [7:0] w_b;

    assign w_b        = i_s_tdata;
    assign o_s_tready = i_q_ready;
    assign w_accept   = i_s_tvalid && i_q_ready;
    assign w_cont     = (w_b & CONT_MASK) == CONT_CODE;

    always_comb begin
        n_held_count = r_held_count;
        n_seq_len    = r_seq_len;
        w_taken      = 1'b0;
        w_emit       = 1'b0;
        w_emit_held  = 2'd0;
        w_wr_en      = 1'b0;
        w_wr_idx     = r_held_count;

        if (r_seq_len != SEQ_NONE) begin
            if (w_cont) begin
                w_taken = 1'b1;
                if (({1'b0, r_held_count} + 3'd1) >= r_seq_len) begin
                    // sequence complete: release held bytes plus this one
                    w_emit       = 1'b1;
                    w_emit_held  = r_held_count;
                    n_held_count = 2'd0;
                    n_seq_len    = SEQ_NONE;
                end else begin
                    w_wr_en      = 1'b1;
                    n_held_count = r_held_count + 2'd1;
                end
            end else begin
                n_held_count = 2'd0;
                n_seq_len    = SEQ_NONE;
            end
        end

        // byte judged as if no sequence were open
        if (!w_taken) begin
            if (w_b == 8'd0) begin
                n_held_count = 2'd0;
                n_seq_len    = SEQ_NONE;
            end else if (!w_b[7]) begin
                w_emit      = 1'b1;
                w_emit_held = 2'd0;
            end else if (lead_length(w_b) != SEQ_NONE) begin
                w_wr_en      = 1'b1;
                w_wr_idx     = 2'd0;
                n_held_count = 2'd1;
                n_seq_len    = lead_length(w_b);
            end
        end

        if (i_s_tlast) begin
            n_held_count = 2'd0;
            n_seq_len    = SEQ_NONE;
        end
    end

    assign o_q_push = w_accept && w_emit;

    always_comb begin
        o_q_burst.bytes[0] = (w_emit_held > 2'd0) ? r_held[0] : w_b;
        o_q_burst.bytes[1] = (w_emit_held > 2'd1) ? r_held[1] : w_b;
        o_q_burst.bytes[2] = (w_emit_held > 2'd2) ? r_held[2] : w_b;
        o_q_burst.bytes[3] = w_b;
        o_q_burst.last_idx = w_emit_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
            r_seq_len    <= SEQ_NONE;
        end else if (w_accept) begin
            r_held_count <= n_held_count;
            r_seq_len    <= n_seq_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_wr_en) begin
            r_held[w_wr_idx] <= w_b;
        end
    end

endmodule

// File: design/usf_queue.sv
// short burst queue between front end and output serializer
`timescale 1ns / 1ps

module usf_queue #(
    parameter int DEPTH = usf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  usf_pkg::t_burst i_burst,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output usf_pkg::t_burst o_head
);
    import usf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_burst        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic          w_wr;
    logic          w_rd;

    assign o_ready = r_count != CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_burst;
        end
    end

endmodule

// File: design/usf_back.sv
// back end: serializes bursts into the registered output stream
`timescale 1ns / 1ps

module usf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  usf_pkg::t_burst i_q_head,
    output logic            o_q_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] clean_byte
    output logic            o_m_tlast    // run_last
);
    import usf_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_pos;

    logic       w_slot_free;
    logic       w_load;
    logic       w_at_end;

    assign w_slot_free = !r_valid || i_m_tready;
    assign w_load      = w_slot_free && i_q_valid;
    assign w_at_end    = r_pos == i_q_head.last_idx;
    assign o_q_pop     = w_load && w_at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 2'd0;
        end else begin
            if (w_slot_free) begin
                r_valid <= i_q_valid;
            end
            if (w_load) begin
                r_pos <= w_at_end ? 2'd0 : r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_q_head.bytes[r_pos];
            r_last <= w_at_end;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tlast  = r_last;

endmodule

// File: design/utf8_sequence_filter.sv
// utf-8 sequence filter top level: front end, burst queue and output serializer
`timescale 1ns / 1ps

// Takes one text byte per cycle and passes on only UTF-8 sequences whose lead
// and continuation bit patterns fit, without checking code point ranges: ASCII
// bytes go through at once, multi-byte sequences are held and released whole
// when complete, broken sequences, stray continuations and invalid leads are
// dropped, and a zero byte or tlast closes the string. An input byte is
// judged in the cycle it is accepted; the bytes it releases (zero to four)
// enter a QUEUE_DEPTH-entry burst queue and leave one byte per cycle, while
// the output is ready, through a registered output stage. Input is taken
// every cycle while the queue has room; the output serializer moves one byte
// per cycle while the output is ready, so the sustained input rate is one byte
// per cycle as long as released bytes average at most one per item.
// The last byte released by each input transaction carries tlast.

module utf8_sequence_filter #(
    parameter int QUEUE_DEPTH = usf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  logic       i_s_tlast,   // string_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] clean_byte
    output logic       o_m_tlast    // run_last
);
    import usf_pkg::*;

    `include "utf8_sequence_filter_macros.svh"

    logic   w_q_ready;
    logic   w_push;
    t_burst w_burst;
    logic   w_q_valid;
    t_burst w_head;
    logic   w_pop;

    usf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_ready  (w_q_ready),
        .o_q_push   (w_push),
        .o_q_burst  (w_burst)
    );

    usf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_burst (w_burst),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    usf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_head   (w_head),
        .o_q_pop    (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // the serializer only retires a burst that is really queued
    `USF_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, w_pop, w_q_valid, "pop from empty queue")

    // input only stalls while the queue holds work
    `USF_ASSERT_NOW(a_stall_has_work, i_clk, i_rst_n, !o_s_tready, w_q_valid,
        "input stalled with empty queue")

    // retiring a burst loads its last byte into the output register
    `USF_ASSERT_NEXT(a_pop_marks_last, i_clk, i_rst_n, w_pop, o_m_tvalid && o_m_tlast,
        "burst retired without last byte")

    // queued work reaches a free output slot in the next cycle
    `USF_ASSERT_NEXT(a_no_bubble, i_clk, i_rst_n, w_q_valid && (!o_m_tvalid || i_m_tready),
        o_m_tvalid, "output bubble with queued work")

endmodule

// File: test/utf8_sequence_filter_tb.sv
// self-checking testbench for the utf-8 sequence filter
`timescale 1ns / 1ps

module utf8_sequence_filter_tb;
    import usf_pkg::*;

    localparam int  WATCHDOG_LIMIT = 1000;
    localparam int  DRAIN_CYCLES   = 16;
    localparam logic TYPED   = 1'b1;
    localparam logic PREDICT = 1'b0;
    localparam logic [0:3][7:0] NO_REL = '0;

    // one input byte; typed rows carry the bytes they must release
    typedef struct packed {
        logic [7:0]      text;
        logic            fin;
        logic            typed;
        logic [2:0]      n_rel;
        logic [0:3][7:0] rel;
    } t_stim_row;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } t_clean_out;

    localparam t_stim_row DIRECTED [26] = '{
        '{8'h41, 1'b0, TYPED,   3'd1, {8'h41, 24'h0}},
        '{8'h7F, 1'b0, TYPED,   3'd1, {8'h7F, 24'h0}},
        '{8'h00, 1'b0, TYPED,   3'd0, NO_REL},
        '{8'hC3, 1'b0, PREDICT, 3'd0, NO_REL},
        '{8'hA9, 1'b0, TYPED,   3'd2, {8'hC3, 8'hA9, 16'h0}},
        '{8'hE2, 1'b0, PREDICT, 3'd0, NO_REL},
        '{8'h82, 1'b0, PREDICT, 3'd0, NO_REL},
        '{8'hAC, 1'b0, TYPED,   3'd3, {8'hE2, 8'h82, 8'hAC, 8'h00}},
        '{8'hF0, 1'b0, PREDICT, 3'd0, NO_REL},
        '{8'h9F, 1'b0, PREDICT, 3'd0, NO_REL},
        '{8'h98, 1'b0, PREDICT, 3'd0, NO_REL},
        '{8'h80, 1'b0, TYPED,   3'd4, {8'hF0, 8'h9F, 8'h98, 8'h80}},
        '{8'h80, 1'b0, TYPED,   3'd0, NO_REL},
        '{8'hFF, 1'b0, TYPED,   3'd0, NO_REL},
        '{8'hF8, 1'b0, TYPED,   3'd0, NO_REL},
        '{8'hC3, 1'b0, PREDICT, 3'd0, NO_REL},
        '{8'h41, 1'b0, TYPED,   3'd1, {8'h41, 24'h0}},
        '{8'hE2, 1'b0, PREDICT, 3'd0, NO_REL},
        '{8'h82, 1'b0, PREDICT, 3'd0, NO_REL},
        '{8'hC3, 1'b0, PREDICT, 3'd0, NO_REL},
        '{8'hBF, 1'b0, TYPED,   3'd2, {8'hC3, 8'hBF, 16'h0}},
        '{8'hE2, 1'b0, PREDICT, 3'd0, NO_REL},
        '{8'h00, 1'b0, TYPED,   3'd0, NO_REL},
        '{8'hF0, 1'b1, TYPED,   3'd0, NO_REL},
        '{8'h80, 1'b0, TYPED,   3'd0, NO_REL},
        '{8'h42, 1'b1, TYPED,   3'd1, {8'h42, 24'h0}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;

    t_stim_row  pending_rows[$];
    t_stim_row  random_rows[$];
    t_clean_out clean_bytes_due[$];

    // predictor state
    logic [7:0] held_bytes [3];
    int         held_n = 0;
    logic [2:0] open_len = SEQ_NONE;

    // handshakes seen just before the coming edge
    logic       in_seen = 1'b0;
    logic       out_seen = 1'b0;
    logic [7:0] out_byte = 8'h00;
    logic       out_last = 1'b0;

    utf8_sequence_filter DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [7:0] text_byte
        .i_s_tlast  (s_tlast),   // string_end
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // [7:0] clean_byte
        .o_m_tlast  (m_tlast)    // run_last
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // bytes released by one accepted input byte, advancing the held sequence
    function automatic int judge_byte(input logic [7:0] b, input logic fin,
                                      output logic [0:3][7:0] rel);
        int         n;
        logic       taken;
        logic [2:0] len;
        n = 0;
        taken = 1'b0;
        rel = '0;
        if (open_len != SEQ_NONE) begin
            if ((b & CONT_MASK) == CONT_CODE) begin
                taken = 1'b1;
                if (held_n + 1 >= int'(open_len)) begin
                    for (int i = 0; i < held_n; i++) begin
                        rel[n] = held_bytes[i];
                        n++;
                    end
                    rel[n] = b;
                    n++;
                    held_n = 0;
                    open_len = SEQ_NONE;
                end else begin
                    held_bytes[held_n] = b;
                    held_n++;
                end
            end else begin
                // broken sequence: drop it and judge this byte on its own
                held_n = 0;
                open_len = SEQ_NONE;
            end
        end
        if (!taken) begin
            if (b == 8'h00) begin
                held_n = 0;
                open_len = SEQ_NONE;
            end else if (b < 8'h80) begin
                rel[n] = b;
                n++;
            end else begin
                casez (b)
                    8'b110?????: len = SEQ_TWO;
                    8'b1110????: len = SEQ_THREE;
                    8'b11110???: len = SEQ_FOUR;
                    default:     len = SEQ_NONE;
                endcase
                if (len != SEQ_NONE) begin
                    held_bytes[0] = b;
                    held_n = 1;
                    open_len = len;
                end
            end
        end
        if (fin) begin
            held_n = 0;
            open_len = SEQ_NONE;
        end
        return n;
    endfunction

    always @(negedge clk) begin
        in_seen  = rst_n && s_tvalid && s_tready;
        out_seen = rst_n && m_tvalid && m_tready;
        out_byte = m_tdata;
        out_last = m_tlast;
    end

    always @(posedge clk) begin : scoreboard
        int              n;
        logic [0:3][7:0] rel;
        t_stim_row       row;
        t_clean_out      due;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (in_seen) begin
            row = pending_rows.pop_front();
            n = judge_byte(row.text, row.fin, rel);
            if (row.typed) begin
                n = row.n_rel;
                rel = row.rel;
            end
            for (int i = 0; i < n; i++) begin
                due.text = rel[i];
                due.last = (i == n - 1);
                clean_bytes_due.insert(clean_bytes_due.size(), due);
            end
        end
        if (out_seen) begin
            if (clean_bytes_due.size() == 0) begin
                $display("%0t: unexpected transaction, actual %h last %b",
                         $time, out_byte, out_last);
                errors++;
            end else begin
                due = clean_bytes_due.pop_front();
                if (due.text != out_byte) begin
                    $display("%0t: clean_byte expected %h actual %h",
                             $time, due.text, out_byte);
                end
                if (due.last != out_last) begin
                    $display("%0t: run_last expected %b actual %b",
                             $time, due.last, out_last);
                end
                if (due.text != out_byte || due.last != out_last) begin
                    errors++;
                end
            end
        end
        if (rst_n && !in_seen && !out_seen) begin
            quiet_cycles++;
        end else begin
            quiet_cycles = 0;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_row(input t_stim_row row);
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        pending_rows.insert(pending_rows.size(), row);
        s_tvalid <= 1'b1;
        s_tdata  <= row.text;
        s_tlast  <= row.fin;
        do begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
    endtask

    // sender holds off until every expected byte has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (clean_bytes_due.size() != 0 || pending_rows.size() != 0) begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic void push_random(input logic [7:0] b);
        t_stim_row row;
        row = '{b, $urandom_range(0, 24) == 0, PREDICT, 3'd0, NO_REL};
        random_rows.insert(random_rows.size(), row);
    endfunction

    // mostly well-formed characters, some truncated sequences, noise and nul
    function automatic void add_random_chunk();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            push_random(8'($urandom_range(1, 127)));
        end else if (pick < 82) begin
            len = (pick < 55) ? 2 : (pick < 70) ? 3 : 4;
            push_random(lead_byte(len));
            repeat (len - 1) push_random(cont_byte());
        end else if (pick < 90) begin
            len = $urandom_range(2, 4);
            push_random(lead_byte(len));
            repeat ($urandom_range(0, len - 2)) push_random(cont_byte());
        end else if (pick < 97) begin
            push_random(8'($urandom_range(0, 255)));
        end else begin
            push_random(8'h00);
        end
    endfunction

    task automatic run_random(input int idle, input int stall, input int count);
        send_idle_pct = idle;
        stall_pct = stall;
        random_rows.delete();
        while (random_rows.size() < count) add_random_chunk();
        foreach (random_rows[k]) send_row(random_rows[k]);
        drain();
    endtask

    initial begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        foreach (DIRECTED[k]) send_row(DIRECTED[k]);
        drain();
        run_random(0, 0, 75);
        run_random(63, 0, 75);
        run_random(0, 63, 75);
        run_random(27, 27, 75);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (clean_bytes_due.size() != 0) begin
            $display("%0t: %0d expected bytes never arrived", $time, clean_bytes_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/usf_pkg.sv
design/usf_front.sv
design/usf_queue.sv
design/usf_back.sv
design/utf8_sequence_filter.sv
test/utf8_sequence_filter_tb.sv
